@@ rtl/core/dsdpcm_pkg.sv @@
// shared types and constants for the dsd to pcm decimator
`default_nettype none
package dsdpcm_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegChannels = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDecim    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTaps     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGain     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDither   = 3'd4;
  localparam logic OpLoad = 1'b0;
  localparam logic OpData = 1'b1;
  localparam logic [31:0] NoiseSeed = 32'h6d2b79f5;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/dsdpcm_ram.sv @@
// generic ram with one write port and one registered read port
`default_nettype none
module dsdpcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/dsdpcm_lane.sv @@
// one channel lane: accumulates the signed tap sum over eight taps per row
`default_nettype none
module dsdpcm_lane #(
  parameter int unsigned AccW = 42
) (
  input  wire logic              clk_i,
  input  wire logic              clr_i,
  input  wire logic              en_i,
  input  wire logic [7:0]        bits_i,
  input  wire logic [7:0]        tap_en_i,
  input  wire logic [8*32-1:0]   taps_i,
  output logic signed [AccW-1:0] acc_o
);
  logic signed [AccW-1:0] acc_q, row_sum;
  always_comb begin
    row_sum = '0;
    for (int b = 0; b < 8; b++) begin
      if (tap_en_i[b]) begin
        if (bits_i[7-b]) row_sum = row_sum + AccW'($signed(taps_i[b*32 +: 32]));
        else             row_sum = row_sum - AccW'($signed(taps_i[b*32 +: 32]));
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (clr_i) acc_q <= '0;
    else if (en_i) acc_q <= acc_q + row_sum;
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

@@ rtl/core/dsdpcm_scale.sv @@
// output stage: gain scaling, dither, clamp and rounding of one sample
`default_nettype none
module dsdpcm_scale #(
  parameter int unsigned AccW = 42,
  parameter int unsigned PcmW = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic signed [AccW-1:0] sum_i,
  input  wire logic [31:0]       gain_i,
  input  wire logic              dither_i,
  output logic                   done_o,
  output logic signed [PcmW-1:0] pcm_o
);
  import dsdpcm_pkg::*;
  localparam logic [63:0] Peak = (64'd1 << (PcmW-1)) - 64'd1;
  typedef enum logic [2:0] {SIdle, SMulA, SMulB, SScale, SOut} st_e;
  st_e st_q;
  logic neg_q, big_q, dneg_q;
  logic [AccW-1:0] s_q;
  logic [63:0] a_q, m_q, rr_q, dmag_q;
  logic [31:0] noise_q, r1, r2;
  logic [63:0] mag, magc, res;
  logic vneg;
  logic signed [PcmW-1:0] pcm_q;

  always_comb begin
    r1 = xorshift(noise_q);
    r2 = xorshift(r1);
    if (dneg_q == neg_q) begin mag = rr_q + dmag_q; vneg = neg_q; end
    else if (rr_q >= dmag_q) begin mag = rr_q - dmag_q; vneg = neg_q; end
    else begin mag = dmag_q - rr_q; vneg = !neg_q; end
    magc = (mag > (Peak << 32)) ? (Peak << 32) : mag;
    res = (magc + (64'd1 << 31)) >> 32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      noise_q <= NoiseSeed;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        SIdle: if (start_i) begin
          neg_q <= sum_i[AccW-1];
          s_q <= sum_i[AccW-1] ? AccW'(-sum_i) : AccW'(sum_i);
          dneg_q <= sum_i[AccW-1];
          dmag_q <= '0;
          big_q <= 1'b0;
          st_q <= SMulA;
        end
        SMulA: begin
          if (dither_i) begin
            noise_q <= r2;
            if (r1 >= r2) begin dmag_q <= 64'(r1 - r2); dneg_q <= 1'b0; end
            else begin dmag_q <= 64'(r2 - r1); dneg_q <= 1'b1; end
          end
          a_q <= 64'(s_q) * 64'(gain_i[31:16]);
          st_q <= SMulB;
        end
        SMulB: begin
          if (a_q[63:43] != '0) big_q <= 1'b1;
          m_q <= (a_q << 16) + 64'(s_q) * 64'(gain_i[15:0]);
          st_q <= SScale;
        end
        SScale: begin
          if (m_q[63:59] != '0) big_q <= 1'b1;
          rr_q <= (m_q >> 26) * Peak + (({38'd0, m_q[25:0]} * Peak) >> 26);
          st_q <= SOut;
        end
        SOut: begin
          if (big_q || rr_q >= ((Peak + 64'd1) << 32))
            pcm_q <= neg_q ? PcmW'(-Peak) : PcmW'(Peak);
          else
            pcm_q <= vneg ? PcmW'(-res) : PcmW'(res);
          done_o <= 1'b1;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end
  assign pcm_o = pcm_q;
endmodule
`default_nettype wire

@@ rtl/core/dsd_to_pcm_decimator.sv @@
// top level of the multi-channel dsd to pcm fir decimator
// usage:
//   in channel (in_valid_i / in_stall_o): op selects a tap load or a byte group
//   a tap load gives no result
//   a byte group writes one byte per channel into the ring histories; once
//   warm-up is over and the decimation count allows, a frame is computed
//   out channel (out_valid_o / out_stall_i): one item per channel in use,
//   channel order, last_of_frame on the last channel
//   compute: one lane per channel walks the history rows, one row of eight taps
//   per cycle; then the shared scaling unit scales the channels one after
//   another
//   each result waits in the output register until taken
//   a stalled output holds the item and freezes the sequencer
//   reset: taps and history zero via a clearing pass (one row of every tap
//   bank and every lane cleared per cycle), in_stall_o high meanwhile
//   geometry register writes in the idle or load state start the same clearing pass, history only
`default_nettype none
module dsd_to_pcm_decimator #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_TAPS = 512,
  parameter int unsigned PCM_WIDTH = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [dsdpcm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dsdpcm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic op_i,
  input  wire logic [8:0] tap_index_i,
  input  wire logic signed [31:0] tap_value_i,
  input  wire logic [7:0] dsd_ch0_i,
  input  wire logic [7:0] dsd_ch1_i,
  input  wire logic [7:0] dsd_ch2_i,
  input  wire logic [7:0] dsd_ch3_i,
  input  wire logic [7:0] dsd_ch4_i,
  input  wire logic [7:0] dsd_ch5_i,
  input  wire logic [7:0] dsd_ch6_i,
  input  wire logic [7:0] dsd_ch7_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [2:0] channel_index_o,
  output logic signed [PCM_WIDTH-1:0] pcm_sample_o,
  output logic last_of_frame_o
);
  import dsdpcm_pkg::*;
  localparam int unsigned Rows = (MAX_TAPS + 7) / 8;
  localparam int unsigned RowW = $clog2(Rows);
  localparam int unsigned RowCW = $clog2(Rows + 1);
  localparam int unsigned AccW = 32 + $clog2(MAX_TAPS) + 2;
  localparam int unsigned ChW = $clog2(MAX_CHANNELS) > 0 ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned TapW = $clog2(MAX_TAPS + 1);

  typedef enum logic [2:0] {SClear, SIdle, SLoad, SSum, SSumEnd, SScale, SOut} st_e;
  st_e st_q;

  // configuration registers
  logic [3:0] chans_q; logic [2:0] decim_q; logic [9:0] taps_q;
  logic [31:0] gain_q; logic dith_q;
  logic [3:0] ch_eff; logic [2:0] dec_eff; logic [TapW-1:0] taps_eff;
  logic [RowCW-1:0] rows;
  always_comb begin
    ch_eff = (chans_q == 0) ? 4'd1 : (chans_q > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chans_q;
    dec_eff = (decim_q == 0) ? 3'd1 : (decim_q > 3'd4) ? 3'd4 : decim_q;
    taps_eff = (taps_q == 0) ? TapW'(1) :
               (32'(taps_q) > MAX_TAPS) ? TapW'(MAX_TAPS) : TapW'(taps_q);
    rows = RowCW'((32'(taps_eff) + 7) / 8);
  end
  logic geo_wr;
  assign geo_wr = cfg_we_i && (cfg_index_i == RegChannels || cfg_index_i == RegDecim ||
                               cfg_index_i == RegTaps);

  // stream state
  logic [RowW-1:0] ring_q, clr_q, row_q;
  logic [RowCW-1:0] fill_q, cnt_q;
  logic [1:0] skip_q;
  logic [3:0] ch_q;
  logic tclr_q;
  logic [7:0] bytes [MAX_CHANNELS];
  assign bytes[0] = dsd_ch0_i;
  if (MAX_CHANNELS > 1) assign bytes[1] = dsd_ch1_i;
  if (MAX_CHANNELS > 2) assign bytes[2] = dsd_ch2_i;
  if (MAX_CHANNELS > 3) assign bytes[3] = dsd_ch3_i;
  if (MAX_CHANNELS > 4) assign bytes[4] = dsd_ch4_i;
  if (MAX_CHANNELS > 5) assign bytes[5] = dsd_ch5_i;
  if (MAX_CHANNELS > 6) assign bytes[6] = dsd_ch6_i;
  if (MAX_CHANNELS > 7) assign bytes[7] = dsd_ch7_i;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != SIdle);

  // tap memory: eight banks, row addressed, cleared only by the pass after reset
  logic [8*32-1:0] tap_rd;
  logic [RowW-1:0] hist_raddr, hist_waddr, tap_raddr;
  logic [RowW:0] pos_sum;
  logic [TapW-1:0] tap_idx_x;
  assign tap_idx_x = TapW'(tap_index_i);
  assign pos_sum = {1'b0, ring_q} + {1'b0, row_q};
  assign hist_raddr = (RowCW'(pos_sum) >= rows) ? RowW'(RowCW'(pos_sum) - rows) : pos_sum[RowW-1:0];
  assign tap_raddr = row_q;
  for (genvar b = 0; b < 8; b++) begin : g_tap
    dsdpcm_ram #(.Width(32), .Depth(Rows)) u_tap (
      .clk_i, .we_i((st_q == SClear && tclr_q) ||
                    (in_acc && op_i == OpLoad && 32'(tap_index_i) < MAX_TAPS &&
                     tap_idx_x[2:0] == 3'(b))),
      .waddr_i((st_q == SClear) ? clr_q : RowW'(tap_idx_x >> 3)),
      .wdata_i((st_q == SClear) ? 32'd0 : tap_value_i),
      .raddr_i(tap_raddr), .rdata_o(tap_rd[b*32 +: 32]));
  end

  // lanes
  logic signed [AccW-1:0] acc [MAX_CHANNELS];
  logic [7:0] tap_en_q;
  logic lane_clr, lane_en;
  logic [RowCW-1:0] rd_row_q;
  always_comb begin
    for (int b = 0; b < 8; b++)
      tap_en_q[b] = (32'(rd_row_q) * 8 + b) < 32'(taps_eff);
  end
  assign hist_waddr = (st_q == SClear) ? clr_q : ring_q;
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    logic [7:0] hrd;
    dsdpcm_ram #(.Width(8), .Depth(Rows)) u_hist (
      .clk_i, .we_i((st_q == SClear) || (in_acc && op_i == OpData && 4'(c) < ch_eff)),
      .waddr_i(hist_waddr), .wdata_i((st_q == SClear) ? 8'd0 : bytes[c]),
      .raddr_i(hist_raddr), .rdata_o(hrd));
    dsdpcm_lane #(.AccW(AccW)) u_lane (
      .clk_i, .clr_i(lane_clr), .en_i(lane_en), .bits_i(hrd),
      .tap_en_i(tap_en_q), .taps_i(tap_rd), .acc_o(acc[c]));
  end

  // scaling unit
  logic sc_start, sc_done;
  logic signed [PCM_WIDTH-1:0] sc_pcm;
  dsdpcm_scale #(.AccW(AccW), .PcmW(PCM_WIDTH)) u_scale (
    .clk_i, .rst_ni, .start_i(sc_start), .sum_i(acc[ch_q[ChW-1:0]]),
    .gain_i(gain_q), .dither_i(dith_q), .done_o(sc_done), .pcm_o(sc_pcm));

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;
  logic [RowW-1:0] ring_nx;
  assign ring_nx = (RowCW'(ring_q) + 1'b1 >= rows) ? '0 : RowW'(ring_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear; clr_q <= '0; ring_q <= '0; fill_q <= '0; skip_q <= '0;
      tclr_q <= 1'b1;
      chans_q <= 4'd2; decim_q <= 3'd4; taps_q <= 10'd512;
      gain_q <= 32'h1000_0000; dith_q <= 1'b0;
      row_q <= '0; rd_row_q <= '0; cnt_q <= '0; ch_q <= '0;
      lane_clr <= 1'b0; lane_en <= 1'b0; sc_start <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      lane_clr <= 1'b0; sc_start <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegChannels: chans_q <= cfg_data_i[3:0];
          RegDecim:    decim_q <= cfg_data_i[2:0];
          RegTaps:     taps_q <= cfg_data_i[9:0];
          RegGain:     gain_q <= cfg_data_i;
          RegDither:   dith_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // the output stage reloads the register itself
      if (out_acc && st_q != SOut) out_valid_o <= 1'b0;
      case (st_q)
        SClear: begin
          clr_q <= RowW'(clr_q + 1'b1);
          if (clr_q == RowW'(Rows - 1)) begin
            st_q <= SIdle; tclr_q <= 1'b0;
          end
        end
        SIdle: begin
          if (geo_wr) begin
            st_q <= SClear; clr_q <= '0; ring_q <= '0; fill_q <= '0; skip_q <= '0;
          end else if (in_acc && op_i == OpLoad) begin
            st_q <= SLoad;
          end else if (in_acc) begin
            ring_q <= ring_nx;
            if (fill_q < rows && fill_q + 1'b1 < rows) begin
              fill_q <= fill_q + 1'b1; st_q <= SLoad;
            end else begin
              if (fill_q < rows) fill_q <= fill_q + 1'b1;
              if (fill_q >= rows && skip_q != 0) begin
                skip_q <= skip_q - 1'b1; st_q <= SLoad;
              end else begin
                skip_q <= 2'(dec_eff - 1'b1);
                st_q <= SSum; row_q <= '0; cnt_q <= '0; lane_clr <= 1'b1;
              end
            end
          end
        end
        SLoad: begin
          if (geo_wr) begin
            st_q <= SClear; clr_q <= '0; ring_q <= '0; fill_q <= '0; skip_q <= '0;
          end else begin
            st_q <= SIdle;
          end
        end
        SSum: begin
          // ring_q already advanced: oldest row sits at ring_q
          rd_row_q <= RowCW'(row_q);
          lane_en <= (cnt_q < rows);
          if (cnt_q < rows) begin
            cnt_q <= cnt_q + 1'b1;
            if (RowCW'(row_q) + 1'b1 < rows) row_q <= RowW'(row_q + 1'b1);
          end else begin
            st_q <= SSumEnd;
          end
        end
        SSumEnd: begin
          lane_en <= 1'b0; ch_q <= '0; sc_start <= 1'b1; st_q <= SScale;
        end
        SScale: if (sc_done) st_q <= SOut;
        SOut: if (!out_valid_o || out_acc) begin
          out_valid_o <= 1'b1;
          channel_index_o <= ch_q[2:0];
          pcm_sample_o <= sc_pcm;
          last_of_frame_o <= (ch_q + 1'b1 == ch_eff);
          if (ch_q + 1'b1 == ch_eff) st_q <= SIdle;
          else begin ch_q <= ch_q + 1'b1; sc_start <= 1'b1; st_q <= SScale; end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !in_acc) else $error("item accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(pcm_sample_o))
    else $error("stalled result changed");
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (4'(channel_index_o) < ch_eff)) else $error("channel out of range");
endmodule
`default_nettype wire
